>>> rtl/adcwc_pkg.sv
// ----------------------------------------------------------------------------
// adcwc_pkg
// types, codes and lookup functions shared by the window comparator modules
// ----------------------------------------------------------------------------
package adcwc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] RESULT_RESET   = 16'hAAAA;
    localparam logic [15:0] HIGH_THR_RESET = 16'h0FFF;
    localparam logic [16:0] FULL_SCALE     = 17'h10000;
    localparam logic [3:0]  HOLD_CODES     = 4'd10;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_VREAD = 1'b1;

    typedef enum logic [1:0] {
        RES_8   = 2'd0,
        RES_10  = 2'd1,
        RES_12  = 2'd2,
        RES_BAD = 2'd3
    } t_res_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_RES      = 3'd1,
        CFG_LOW_THR  = 3'd2,
        CFG_HIGH_THR = 3'd3,
        CFG_IRQ_EN   = 3'd4,
        CFG_CLK_SRC  = 3'd5,
        CFG_CLK_DIV  = 3'd6,
        CFG_HOLD     = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_WORK = 1'b1
    } t_back_state;

    typedef struct packed {
        logic        kind;
        logic [16:0] supply_level;
    } t_in_item;

    typedef struct packed {
        logic [15:0] conversion_result;
        logic        converted;
        logic [1:0]  vector_data;
        logic        interrupt;
        logic [18:0] sample_period_clocks;
        logic [1:0]  clock_select;
        logic        config_error;
    } t_out_item;

    // classified command held in the queue
    typedef struct packed {
        logic        is_read;
        logic [16:0] level;
    } t_cmd;

    // queue handshake between two modules
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_req;

    function automatic logic [9:0] hold_clocks(input logic [3:0] code);
        logic [9:0] v;
        case (code)
            4'd0:    v = 10'd4;
            4'd1:    v = 10'd8;
            4'd2:    v = 10'd16;
            4'd3:    v = 10'd32;
            4'd4:    v = 10'd64;
            4'd5:    v = 10'd96;
            4'd6:    v = 10'd128;
            4'd7:    v = 10'd256;
            4'd8:    v = 10'd384;
            4'd9:    v = 10'd512;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] conv_clocks(input t_res_code code);
        logic [3:0] v;
        case (code)
            RES_8:   v = 4'd10;
            RES_10:  v = 4'd12;
            RES_12:  v = 4'd14;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // right shift that maps a 1.16 level onto the result width
    function automatic logic [3:0] res_shift(input t_res_code code);
        logic [3:0] v;
        case (code)
            RES_8:   v = 4'd8;
            RES_10:  v = 4'd6;
            RES_12:  v = 4'd4;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // predivider 1/4/32/64 as a left shift
    function automatic logic [2:0] pre_shift(input logic [1:0] code);
        logic [2:0] v;
        case (code)
            2'd0:    v = 3'd0;
            2'd1:    v = 3'd2;
            2'd2:    v = 3'd5;
            default: v = 3'd6;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/adcwc_stream_if.sv
// ----------------------------------------------------------------------------
// adcwc_stream_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface adcwc_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/adc_window_comparator_regs_unit.sv
// ----------------------------------------------------------------------------
// adc_window_comparator_regs_unit
// converter with window comparator, sticky crossing flags and vector read
//
//   channel   dir  payload                                       transfer
//   i_in      in   kind, supply_level                            valid & ready
//   o_out     out  result, flags, irq, period, clock, error      valid & ready
//   i_cfg_*   in   register index 0..7, 16-bit data              i_cfg_we
//
// each item goes through two steps in the back part: execute and period shift
// a 2-entry queue lets the front accept while the back or output stalls
// the output register holds a finished result until it is taken
// synchronous active-low reset; stored result resets to 0xaaaa
// ----------------------------------------------------------------------------
module adc_window_comparator_regs_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [adcwc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [adcwc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    adcwc_stream_if.sink                      i_in,
    adcwc_stream_if.source                    o_out
);

    adcwc_pkg::t_q_req q_push;
    adcwc_pkg::t_q_req q_pop;
    logic              q_push_ready;
    logic              q_pop_ready;

    adcwc_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_push_ready),
        .o_q_req   (q_push)
    );

    adcwc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .o_push_ready (q_push_ready),
        .o_pop        (q_pop),
        .i_pop_ready  (q_pop_ready)
    );

    adcwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pop       (q_pop),
        .o_pop_ready (q_pop_ready),
        .o_out       (o_out)
    );

endmodule

>>> rtl/adcwc_front.sv
// ----------------------------------------------------------------------------
// adcwc_front
// accepts input items, saturates the level and classifies tick or vector read
// ----------------------------------------------------------------------------
module adcwc_front (
    adcwc_stream_if.sink      i_in,
    input  logic              i_q_ready,
    output adcwc_pkg::t_q_req o_q_req
);

    adcwc_pkg::t_cmd cmd;

    always_comb begin
        cmd.is_read = (i_in.payload.kind == adcwc_pkg::KIND_VREAD);
        if (i_in.payload.supply_level > adcwc_pkg::FULL_SCALE) begin
            cmd.level = adcwc_pkg::FULL_SCALE;
        end else begin
            cmd.level = i_in.payload.supply_level;
        end
    end

    assign i_in.ready     = i_q_ready;
    assign o_q_req.valid  = i_in.valid;
    assign o_q_req.cmd    = cmd;

endmodule

>>> rtl/adcwc_queue.sv
// ----------------------------------------------------------------------------
// adcwc_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module adcwc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  adcwc_pkg::t_q_req i_push,
    output logic              o_push_ready,
    output adcwc_pkg::t_q_req o_pop,
    input  logic              i_pop_ready
);

    localparam int DEPTH = adcwc_pkg::QUEUE_DEPTH;
    localparam int PW    = adcwc_pkg::QPTR_W;
    localparam int CW    = adcwc_pkg::QCNT_W;

    adcwc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign push         = i_push.valid && o_push_ready;
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.cmd    = r_mem[r_rd_ptr];
    assign pop          = o_pop.valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + CW'(1))
        else $error("queue count missed a transfer");

endmodule

>>> rtl/adcwc_back.sv
// ----------------------------------------------------------------------------
// adcwc_back
// register file, conversion, window compare, flags and sample period
// ----------------------------------------------------------------------------
module adcwc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [adcwc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [adcwc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  adcwc_pkg::t_q_req                    i_pop,
    output logic                                 o_pop_ready,
    adcwc_stream_if.source                       o_out
);

    // configuration
    logic                   r_en;
    adcwc_pkg::t_res_code   r_res;
    logic [15:0]            r_lo;
    logic [15:0]            r_hi;
    logic [1:0]             r_wie;
    logic [1:0]             r_clk_src;
    logic [4:0]             r_div;
    logic [3:0]             r_hold;

    // block state
    logic [15:0]            r_stored;
    logic [1:0]             r_flags;
    logic                   r_irq;
    logic [15:0]            n_stored;
    logic [1:0]             n_flags;
    logic                   n_irq;

    adcwc_pkg::t_back_state r_state;
    adcwc_pkg::t_back_state n_state;

    adcwc_pkg::t_out_item   r_pend;
    adcwc_pkg::t_out_item   n_pend;
    logic [12:0]            r_prod;
    logic [12:0]            n_prod;
    adcwc_pkg::t_out_item   r_out;
    adcwc_pkg::t_out_item   n_out;
    logic                   r_out_valid;

    logic                   take;
    logic                   load_out;
    logic                   res_bad;
    logic                   hold_bad;
    logic [15:0]            sample;
    logic [3:0]             div_m;
    logic [9:0]             tot;
    logic [18:0]            period;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            adcwc_pkg::BK_IDLE: begin
                if (i_pop.valid) begin
                    n_state = adcwc_pkg::BK_WORK;
                end
            end
            adcwc_pkg::BK_WORK: begin
                if (load_out) begin
                    n_state = adcwc_pkg::BK_IDLE;
                end
            end
            default: n_state = adcwc_pkg::BK_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_pop_ready = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            adcwc_pkg::BK_IDLE: o_pop_ready = 1'b1;
            adcwc_pkg::BK_WORK: load_out    = !r_out_valid || o_out.ready;
            default: begin
                o_pop_ready = 1'b0;
                load_out    = 1'b0;
            end
        endcase
    end

    assign take     = i_pop.valid && o_pop_ready;
    assign res_bad  = (r_res == adcwc_pkg::RES_BAD);
    assign hold_bad = (r_hold >= adcwc_pkg::HOLD_CODES);
    assign sample   = 16'(i_pop.cmd.level >> adcwc_pkg::res_shift(r_res));
    assign div_m    = {1'b0, r_div[2:0]} + 4'd1;
    assign tot      = adcwc_pkg::hold_clocks(r_hold) + {6'd0, adcwc_pkg::conv_clocks(r_res)};
    assign n_prod   = 13'({9'd0, div_m} * {3'd0, tot});
    assign period   = {6'd0, r_prod} << adcwc_pkg::pre_shift(r_div[4:3]);

    // item execution
    always_comb begin
        n_stored = r_stored;
        n_flags  = r_flags;
        n_irq    = r_irq;
        n_pend   = '0;
        if (i_pop.cmd.is_read) begin
            n_pend.vector_data = r_flags;
            n_flags            = '0;
            n_irq              = 1'b0;
        end else if (!r_en) begin
            n_irq = 1'b0;
        end else begin
            if (r_flags == '0) begin
                n_irq = 1'b0;
            end
            if (!res_bad) begin
                n_stored         = sample;
                n_pend.converted = 1'b1;
                if (r_wie[0] && sample < r_lo) begin
                    n_flags[0] = 1'b1;
                    n_irq      = 1'b1;
                end
                if (r_wie[1] && sample > r_hi) begin
                    n_flags[1] = 1'b1;
                    n_irq      = 1'b1;
                end
            end
        end
        n_pend.conversion_result = n_stored;
        n_pend.interrupt         = r_en && n_irq;
        n_pend.clock_select      = r_clk_src;
        n_pend.config_error      = res_bad || hold_bad;
    end

    // finished result with the period filled in
    always_comb begin
        n_out                      = r_pend;
        n_out.sample_period_clocks = period;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_res     <= adcwc_pkg::RES_12;
            r_lo      <= '0;
            r_hi      <= adcwc_pkg::HIGH_THR_RESET;
            r_wie     <= '0;
            r_clk_src <= '0;
            r_div     <= '0;
            r_hold    <= '0;
        end else if (i_cfg_we) begin
            case (adcwc_pkg::t_cfg_idx'(i_cfg_idx))
                adcwc_pkg::CFG_ENABLE:   r_en      <= i_cfg_data[0];
                adcwc_pkg::CFG_RES:      r_res     <= adcwc_pkg::t_res_code'(i_cfg_data[1:0]);
                adcwc_pkg::CFG_LOW_THR:  r_lo      <= i_cfg_data;
                adcwc_pkg::CFG_HIGH_THR: r_hi      <= i_cfg_data;
                adcwc_pkg::CFG_IRQ_EN:   r_wie     <= i_cfg_data[1:0];
                adcwc_pkg::CFG_CLK_SRC:  r_clk_src <= i_cfg_data[1:0];
                adcwc_pkg::CFG_CLK_DIV:  r_div     <= i_cfg_data[4:0];
                adcwc_pkg::CFG_HOLD:     r_hold    <= i_cfg_data[3:0];
                default: r_en <= r_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= adcwc_pkg::BK_IDLE;
            r_stored    <= adcwc_pkg::RESULT_RESET;
            r_flags     <= '0;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_stored <= n_stored;
                r_flags  <= n_flags;
                r_irq    <= n_irq;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pend <= n_pend;
            r_prod <= n_prod;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_irq_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq |-> r_flags != '0)
        else $error("interrupt level without a crossing flag");

    a_irq_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.interrupt |-> r_en)
        else $error("interrupt reported while converter off");

    a_read_no_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.vector_data != '0 |-> !r_out.converted)
        else $error("vector read reported a conversion");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_state == adcwc_pkg::BK_WORK)
        else $error("item taken without entering work state");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the adc window comparator with register port
//
// an initial block writes the registers while the block is idle and fills a
// queue of ticks and vector reads; a clocked driver sends them in bursts with
// random gaps, and a clocked receiver block stalls the output on its own pattern.
// every accepted input is run through a local model of the converter, the
// window flags and the interrupt line, and each output transfer is checked
// against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_SETS  = 12;
    localparam int ITEMS_PER_SET = 37;

    localparam int HOLD_TABLE [16] = '{4, 8, 16, 32, 64, 96, 128, 256, 384, 512,
                                       0, 0, 0, 0, 0, 0};
    localparam int PREDIV_TABLE [4] = '{1, 4, 32, 64};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [adcwc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [adcwc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    adcwc_stream_if #(.T_PAYLOAD(adcwc_pkg::t_in_item))  in_if ();
    adcwc_stream_if #(.T_PAYLOAD(adcwc_pkg::t_out_item)) out_if ();

    adc_window_comparator_regs_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // register copies
    logic                 cfg_enable;
    adcwc_pkg::t_res_code cfg_res;
    logic [15:0]          cfg_low_thr;
    logic [15:0]          cfg_high_thr;
    logic [1:0]           cfg_irq_en;
    logic [1:0]           cfg_clk_src;
    logic [4:0]           cfg_clk_div;
    logic [3:0]           cfg_hold;

    // converter state
    logic [15:0] adc_result   = adcwc_pkg::RESULT_RESET;
    logic [1:0]  window_flags = 2'b00;
    logic        irq_line     = 1'b0;

    adcwc_pkg::t_in_item  pending_cmds[$];
    adcwc_pkg::t_out_item awaited_results[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int stall_mode     = 0;
    int mode_timer     = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic adcwc_pkg::t_out_item predict_conversion(input adcwc_pkg::t_in_item cmd);
        adcwc_pkg::t_out_item r;
        logic [16:0] lvl;
        int unsigned res_bits;
        int unsigned conv_clk;
        int unsigned period;
        logic        res_bad;
        logic        hold_bad;
        r        = '0;
        lvl      = (cmd.supply_level > adcwc_pkg::FULL_SCALE) ? adcwc_pkg::FULL_SCALE
                                                              : cmd.supply_level;
        res_bad  = (cfg_res == adcwc_pkg::RES_BAD);
        hold_bad = (cfg_hold >= 4'd10);
        case (cfg_res)
            adcwc_pkg::RES_8: begin
                res_bits = 8;
                conv_clk = 10;
            end
            adcwc_pkg::RES_10: begin
                res_bits = 10;
                conv_clk = 12;
            end
            adcwc_pkg::RES_12: begin
                res_bits = 12;
                conv_clk = 14;
            end
            default: begin
                res_bits = 0;
                conv_clk = 0;
            end
        endcase
        if (cmd.kind == adcwc_pkg::KIND_VREAD) begin
            r.vector_data = window_flags;
            window_flags  = 2'b00;
            irq_line      = 1'b0;
        end else if (!cfg_enable) begin
            irq_line = 1'b0;
        end else begin
            if (window_flags == 2'b00)
                irq_line = 1'b0;
            if (!res_bad) begin
                adc_result  = 16'((int'(lvl) << res_bits) >> 16);
                r.converted = 1'b1;
                if (cfg_irq_en[0] && adc_result < cfg_low_thr) begin
                    window_flags[0] = 1'b1;
                    irq_line        = 1'b1;
                end
                if (cfg_irq_en[1] && adc_result > cfg_high_thr) begin
                    window_flags[1] = 1'b1;
                    irq_line        = 1'b1;
                end
            end
        end
        period = PREDIV_TABLE[cfg_clk_div[4:3]] * (int'(cfg_clk_div[2:0]) + 1)
                 * (HOLD_TABLE[cfg_hold] + conv_clk);
        r.conversion_result    = adc_result;
        r.interrupt            = cfg_enable ? irq_line : 1'b0;
        r.sample_period_clocks = 19'(period);
        r.clock_select         = cfg_clk_src;
        r.config_error         = res_bad || hold_bad;
        return r;
    endfunction

    task automatic cfg_write(input adcwc_pkg::t_cfg_idx idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            adcwc_pkg::CFG_ENABLE:   cfg_enable   = value[0];
            adcwc_pkg::CFG_RES:      cfg_res      = adcwc_pkg::t_res_code'(value[1:0]);
            adcwc_pkg::CFG_LOW_THR:  cfg_low_thr  = value;
            adcwc_pkg::CFG_HIGH_THR: cfg_high_thr = value;
            adcwc_pkg::CFG_IRQ_EN:   cfg_irq_en   = value[1:0];
            adcwc_pkg::CFG_CLK_SRC:  cfg_clk_src  = value[1:0];
            adcwc_pkg::CFG_CLK_DIV:  cfg_clk_div  = value[4:0];
            adcwc_pkg::CFG_HOLD:     cfg_hold     = value[3:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_cmd(input logic kind, input logic [16:0] level);
        adcwc_pkg::t_in_item c;
        c.kind         = kind;
        c.supply_level = level;
        pending_cmds.push_back(c);
    endtask

    // wait for every transfer to finish, then let the pipeline settle
    task automatic drain();
        while (pending_cmds.size() != 0 || awaited_results.size() != 0 || in_if.valid)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic logic [15:0] with_noise(input logic [15:0] value, input int width);
        logic [15:0] mask;
        mask = 16'((1 << width) - 1);
        return (value & mask) | (16'($urandom) & ~mask);
    endfunction

    function automatic logic [15:0] pick_threshold(input int top);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'h0000;
        else if (sel == 1)
            return 16'hFFFF;
        else
            return 16'($urandom_range(0, top));
    endfunction

    function automatic logic [16:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 17'($urandom);
            1:       return 17'h10000 + 17'($urandom_range(0, 300));
            2:       return 17'h10000 - 17'($urandom_range(0, 300));
            3:       return 17'($urandom_range(0, 300));
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_setup();
        int top;
        logic [1:0] res;
        logic [4:0] div;
        logic [3:0] hold;
        res  = ($urandom_range(0, 9) == 0) ? 2'(adcwc_pkg::RES_BAD)
                                          : 2'($urandom_range(0, 2));
        top  = (res == 2'(adcwc_pkg::RES_8)) ? 256 :
               (res == 2'(adcwc_pkg::RES_10)) ? 1024 : 4096;
        div  = ($urandom_range(0, 4) == 0) ? {5{$urandom_range(0, 1) == 1}}
                                          : 5'($urandom_range(0, 31));
        hold = ($urandom_range(0, 4) == 0) ? 4'd9 : 4'($urandom_range(0, 15));
        cfg_write(adcwc_pkg::CFG_ENABLE, with_noise(16'($urandom_range(0, 6) != 0), 1));
        cfg_write(adcwc_pkg::CFG_RES, with_noise(16'(res), 2));
        cfg_write(adcwc_pkg::CFG_LOW_THR, pick_threshold(top));
        cfg_write(adcwc_pkg::CFG_HIGH_THR, pick_threshold(top));
        cfg_write(adcwc_pkg::CFG_IRQ_EN, with_noise(16'($urandom_range(0, 3)), 2));
        cfg_write(adcwc_pkg::CFG_CLK_SRC, with_noise(16'($urandom_range(0, 3)), 2));
        cfg_write(adcwc_pkg::CFG_CLK_DIV, with_noise(16'(div), 5));
        cfg_write(adcwc_pkg::CFG_HOLD, with_noise(16'(hold), 4));
        cfg_close();
    endtask

    // driver: bursts of transfers with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.payload <= '0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left != 0) begin
                gap_left    <= gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                in_if.valid   <= 1'b1;
                in_if.payload <= pending_cmds.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // monitor: prediction on input transfer, check on output transfer
    always @(posedge i_clk) begin : monitor
        adcwc_pkg::t_out_item want;
        adcwc_pkg::t_out_item got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                awaited_results.push_back(predict_conversion(in_if.payload));
            if (out_if.valid && out_if.ready) begin
                got = out_if.payload;
                if (awaited_results.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected transfer: res=%h conv=%b vec=%b irq=%b",
                                 got.conversion_result, got.converted,
                                 got.vector_data, got.interrupt);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.conversion_result !== want.conversion_result ||
                        got.converted !== want.converted ||
                        got.vector_data !== want.vector_data ||
                        got.interrupt !== want.interrupt ||
                        got.sample_period_clocks !== want.sample_period_clocks ||
                        got.clock_select !== want.clock_select ||
                        got.config_error !== want.config_error) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10) begin
                            $display("mismatch exp: res=%h conv=%b vec=%b irq=%b per=%0d clk=%0d err=%b",
                                     want.conversion_result, want.converted,
                                     want.vector_data, want.interrupt,
                                     want.sample_period_clocks, want.clock_select,
                                     want.config_error);
                            $display("         got: res=%h conv=%b vec=%b irq=%b per=%0d clk=%0d err=%b",
                                     got.conversion_result, got.converted,
                                     got.vector_data, got.interrupt,
                                     got.sample_period_clocks, got.clock_select,
                                     got.config_error);
                        end
                    end
                end
            end
        end
    end

    // receiver stall pattern, mode picked anew each time its timer runs out
    always @(posedge i_clk) begin
        if (mode_timer == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_timer <= 63;
        end else begin
            mode_timer <= mode_timer - 1;
        end
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (stall_mode == 1) begin
            out_if.ready <= ($urandom_range(0, 1) == 1);
        end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(1, 12);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        cfg_enable     = 1'b0;
        cfg_res        = adcwc_pkg::RES_12;
        cfg_low_thr    = 16'h0000;
        cfg_high_thr   = adcwc_pkg::HIGH_THR_RESET;
        cfg_irq_en     = 2'b00;
        cfg_clk_src    = 2'd0;
        cfg_clk_div    = 5'd0;
        cfg_hold       = 4'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, converter off
        push_cmd(adcwc_pkg::KIND_TICK, 17'h10000);
        push_cmd(adcwc_pkg::KIND_VREAD, 17'h1FFFF);
        push_cmd(adcwc_pkg::KIND_TICK, 17'h00000);
        drain();

        // 12 bit, both crossings, longest period
        cfg_write(adcwc_pkg::CFG_ENABLE, 16'd1);
        cfg_write(adcwc_pkg::CFG_RES, 16'(adcwc_pkg::RES_12));
        cfg_write(adcwc_pkg::CFG_LOW_THR, 16'h0100);
        cfg_write(adcwc_pkg::CFG_HIGH_THR, 16'h0F00);
        cfg_write(adcwc_pkg::CFG_IRQ_EN, 16'd3);
        cfg_write(adcwc_pkg::CFG_CLK_SRC, 16'd3);
        cfg_write(adcwc_pkg::CFG_CLK_DIV, 16'd31);
        cfg_write(adcwc_pkg::CFG_HOLD, 16'd9);
        cfg_close();
        push_cmd(adcwc_pkg::KIND_TICK, 17'h00000);
        push_cmd(adcwc_pkg::KIND_TICK, 17'h1FFFF);
        push_cmd(adcwc_pkg::KIND_TICK, 17'h10000);
        push_cmd(adcwc_pkg::KIND_TICK, 17'h08000);
        push_cmd(adcwc_pkg::KIND_VREAD, 17'h00000);
        push_cmd(adcwc_pkg::KIND_TICK, 17'h08000);
        push_cmd(adcwc_pkg::KIND_TICK, 17'h0FFFF);
        push_cmd(adcwc_pkg::KIND_VREAD, 17'h1FFFF);
        drain();

        // 8 bit, threshold extremes, invalid hold time
        cfg_write(adcwc_pkg::CFG_RES, 16'(adcwc_pkg::RES_8));
        cfg_write(adcwc_pkg::CFG_LOW_THR, 16'hFFFF);
        cfg_write(adcwc_pkg::CFG_HIGH_THR, 16'h0000);
        cfg_write(adcwc_pkg::CFG_IRQ_EN, 16'd1);
        cfg_write(adcwc_pkg::CFG_CLK_SRC, 16'd1);
        cfg_write(adcwc_pkg::CFG_CLK_DIV, 16'd0);
        cfg_write(adcwc_pkg::CFG_HOLD, 16'd15);
        cfg_close();
        push_cmd(adcwc_pkg::KIND_TICK, 17'h1FFFF);
        push_cmd(adcwc_pkg::KIND_TICK, 17'h00000);
        push_cmd(adcwc_pkg::KIND_VREAD, 17'h00001);
        drain();

        // invalid resolution keeps the stored result
        cfg_write(adcwc_pkg::CFG_RES, 16'(adcwc_pkg::RES_BAD));
        cfg_write(adcwc_pkg::CFG_IRQ_EN, 16'd2);
        cfg_write(adcwc_pkg::CFG_HOLD, 16'd10);
        cfg_close();
        push_cmd(adcwc_pkg::KIND_TICK, 17'h12345);
        push_cmd(adcwc_pkg::KIND_VREAD, 17'h0AAAA);
        drain();

        // 10 bit low crossing, then off with flags kept, then on again
        cfg_write(adcwc_pkg::CFG_RES, 16'(adcwc_pkg::RES_10));
        cfg_write(adcwc_pkg::CFG_LOW_THR, 16'h0200);
        cfg_write(adcwc_pkg::CFG_HIGH_THR, 16'h0300);
        cfg_write(adcwc_pkg::CFG_IRQ_EN, 16'd3);
        cfg_write(adcwc_pkg::CFG_CLK_SRC, 16'd2);
        cfg_write(adcwc_pkg::CFG_CLK_DIV, 16'd8);
        cfg_write(adcwc_pkg::CFG_HOLD, 16'd0);
        cfg_close();
        push_cmd(adcwc_pkg::KIND_TICK, 17'h01000);
        drain();
        cfg_write(adcwc_pkg::CFG_ENABLE, 16'd0);
        cfg_close();
        push_cmd(adcwc_pkg::KIND_TICK, 17'h0FFFF);
        push_cmd(adcwc_pkg::KIND_TICK, 17'h00000);
        drain();
        cfg_write(adcwc_pkg::CFG_ENABLE, 16'd1);
        cfg_close();
        push_cmd(adcwc_pkg::KIND_TICK, 17'h08000);
        push_cmd(adcwc_pkg::KIND_VREAD, 17'h15555);
        push_cmd(adcwc_pkg::KIND_TICK, 17'h08000);
        drain();

        for (int s = 0; s < RANDOM_SETS; s++) begin
            random_setup();
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if ($urandom_range(0, 3) == 0)
                    push_cmd(adcwc_pkg::KIND_VREAD, 17'($urandom));
                else
                    push_cmd(adcwc_pkg::KIND_TICK, pick_level());
            end
            drain();
        end

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
